// File: design/bis_pkg.sv
package bis_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int POS_W       = 6;
    localparam int VALUE_W     = 16;
    localparam int CNT_W       = 5;
    localparam int BLKOUT_W    = 4;
    localparam int STATUS_W    = 2;
    localparam int PC_W        = 4;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTRANGE = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found_position;
        logic [BLKOUT_W-1:0] block_searched;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_LD_STORE,
        OP_LD_MAX,
        OP_SR_INIT,
        OP_SR_PROBE,
        OP_SR_STEP,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_SEARCH,
        C_LO_GE_HI,
        C_LO_GE_CNT,
        C_SCAN_DONE,
        C_NO_MATCH,
        C_OUT_FREE
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc S_FETCH     = 4'd0;
    localparam t_pc S_DISPATCH  = 4'd1;
    localparam t_pc S_LD_STORE  = 4'd2;
    localparam t_pc S_LD_MAX    = 4'd3;
    localparam t_pc S_SR_INIT   = 4'd4;
    localparam t_pc S_SR_PROBE  = 4'd5;
    localparam t_pc S_SR_STEP   = 4'd6;
    localparam t_pc S_SCAN_INIT = 4'd7;
    localparam t_pc S_SCAN_RD   = 4'd8;
    localparam t_pc S_SCAN_CMP  = 4'd9;
    localparam t_pc S_EMIT      = 4'd10;
    localparam t_pc S_EMIT_WAIT = 4'd11;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic is_search;
        logic lo_ge_hi;
        logic lo_ge_cnt;
        logic scan_done;
        logic no_match;
        logic out_free;
    } t_flags;

    // Control store. A step jumps to its target when its condition holds,
    // otherwise it falls through to the next step.
    function automatic t_uword ucode(input t_pc addr);
        t_uword w;
        unique case (addr)
            S_FETCH:     w = '{OP_ACCEPT,    C_NO_INPUT,  S_FETCH};
            S_DISPATCH:  w = '{OP_NOP,       C_IS_SEARCH, S_SR_INIT};
            S_LD_STORE:  w = '{OP_LD_STORE,  C_NEVER,     S_FETCH};
            S_LD_MAX:    w = '{OP_LD_MAX,    C_ALWAYS,    S_EMIT};
            S_SR_INIT:   w = '{OP_SR_INIT,   C_NEVER,     S_FETCH};
            S_SR_PROBE:  w = '{OP_SR_PROBE,  C_LO_GE_HI,  S_SCAN_INIT};
            S_SR_STEP:   w = '{OP_SR_STEP,   C_ALWAYS,    S_SR_PROBE};
            S_SCAN_INIT: w = '{OP_SCAN_INIT, C_LO_GE_CNT, S_EMIT};
            S_SCAN_RD:   w = '{OP_SCAN_RD,   C_SCAN_DONE, S_EMIT};
            S_SCAN_CMP:  w = '{OP_SCAN_CMP,  C_NO_MATCH,  S_SCAN_RD};
            S_EMIT:      w = '{OP_EMIT,      C_OUT_FREE,  S_FETCH};
            S_EMIT_WAIT: w = '{OP_NOP,       C_ALWAYS,    S_EMIT};
            default:     w = '{OP_NOP,       C_ALWAYS,    S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// File: design/bis_ram.sv
module bis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bis_sequencer.sv
module bis_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bis_pkg::t_flags i_flags,
    output bis_pkg::t_op    o_op
);

    import bis_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword word;
    logic   take;

    assign word = ucode(r_pc);
    assign o_op = word.op;

    always_comb begin
        unique case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = !i_flags.in_valid;
            C_IS_SEARCH: take = i_flags.is_search;
            C_LO_GE_HI:  take = i_flags.lo_ge_hi;
            C_LO_GE_CNT: take = i_flags.lo_ge_cnt;
            C_SCAN_DONE: take = i_flags.scan_done;
            C_NO_MATCH:  take = i_flags.no_match;
            C_OUT_FREE:  take = i_flags.out_free;
            default:     take = 1'b1;
        endcase
        n_pc = take ? word.target : t_pc'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // A taken jump at the fetch step means no transaction was present.
    a_fetch_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_FETCH && !i_flags.in_valid) |=> (r_pc == S_FETCH))
        else $error("sequencer left fetch without a transaction");

    a_emit_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMIT && i_flags.out_free) |=> (r_pc == S_FETCH))
        else $error("sequencer did not return to fetch after emitting");

    a_pc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= S_EMIT_WAIT)
        else $error("sequencer step counter outside the control store");

endmodule

// File: design/bis_datapath.sv
module bis_datapath #(
    parameter int BLOCK_SIZE = 4,
    parameter int NUM_BLOCKS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bis_pkg::t_op                  i_op,
    input  logic                          i_in_valid,
    input  bis_pkg::t_in_item             i_in_data,
    input  logic                          i_cfg_wr_en,
    input  logic [bis_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic                          i_out_stall,
    output bis_pkg::t_flags               o_flags,
    output logic                          o_out_valid,
    output bis_pkg::t_out_item            o_out_data
);

    import bis_pkg::*;

    localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int WIDE_W = BLK_W + POS_W;
    localparam int SP_W   = CNT_W + $clog2(BLOCK_SIZE + 1) + 1;

    logic                r_kind;
    logic [POS_W-1:0]    r_pos;
    logic [VALUE_W-1:0]  r_key;
    logic [CNT_W-1:0]    r_block_count;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_mid;
    logic [SP_W-1:0]     r_scan_pos;
    logic [SP_W-1:0]     r_scan_end;
    logic [STATUS_W-1:0] r_status;
    logic [POS_W-1:0]    r_fpos;
    logic [BLKOUT_W-1:0] r_blk;
    logic                r_out_valid;
    t_out_item           r_out_data;

    // Block number and first-in-block flag of every store position.
    logic [POS_W-1:0]       blk_tab [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] first_tab;

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_tab
        assign blk_tab[g]   = POS_W'(g / BLOCK_SIZE);
        assign first_tab[g] = ((g % BLOCK_SIZE) == 0);
    end

    logic [POS_W-1:0]   load_blk;
    logic               load_first;
    logic               load_in_range;
    logic [WIDE_W-1:0]  load_wide;
    logic [BLK_W-1:0]   load_addr;
    logic [CNT_W-1:0]   eff_cnt;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid_c;
    logic [WIDE_W-1:0]  mid_wide;
    logic [SP_W-1:0]    scan_base;
    logic               out_free;

    logic               ds_we;
    logic [POS_W-1:0]   ds_raddr;
    logic [VALUE_W-1:0] ds_rdata;
    logic               bm_we;
    logic [BLK_W-1:0]   bm_raddr;
    logic [VALUE_W-1:0] bm_wdata;
    logic [VALUE_W-1:0] bm_rdata;

    assign load_blk      = blk_tab[r_pos];
    assign load_first    = first_tab[r_pos];
    assign load_wide     = WIDE_W'(load_blk);
    assign load_addr     = load_wide[BLK_W-1:0];
    assign load_in_range = (load_wide < WIDE_W'(NUM_BLOCKS));

    assign eff_cnt = (WIDE_W'(r_block_count) > WIDE_W'(NUM_BLOCKS)) ?
                     CNT_W'(NUM_BLOCKS) : r_block_count;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c    = mid_sum[CNT_W:1];
    assign mid_wide = WIDE_W'(mid_c);

    assign scan_base = SP_W'(r_lo) * SP_W'(BLOCK_SIZE);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        ds_we    = (i_op == OP_LD_STORE);
        ds_raddr = r_scan_pos[POS_W-1:0];
        bm_we    = 1'b0;
        bm_raddr = load_addr;
        bm_wdata = r_key;
        unique case (i_op)
            OP_SR_PROBE: bm_raddr = mid_wide[BLK_W-1:0];
            OP_LD_MAX:   bm_we = load_in_range && (load_first || (r_key > bm_rdata));
            default:     bm_we = 1'b0;
        endcase
    end

    bis_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_data_store (
        .i_clk   (i_clk),
        .i_we    (ds_we),
        .i_waddr (r_pos),
        .i_wdata (r_key),
        .i_raddr (ds_raddr),
        .o_rdata (ds_rdata)
    );

    bis_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_BLOCKS)) u_block_max (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (load_addr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    r_kind <= i_in_data.kind;
                    r_pos  <= i_in_data.position;
                    r_key  <= i_in_data.value;
                end
            end
            OP_LD_MAX: begin
                r_status <= ST_LOADED;
                r_fpos   <= '0;
                r_blk    <= '0;
            end
            OP_SR_INIT: begin
                r_lo <= '0;
                r_hi <= eff_cnt;
            end
            OP_SR_PROBE: begin
                r_mid <= mid_c;
            end
            OP_SR_STEP: begin
                if (bm_rdata < r_key) begin
                    r_lo <= CNT_W'(r_mid + 1'b1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            OP_SCAN_INIT: begin
                r_scan_pos <= scan_base;
                r_scan_end <= SP_W'(scan_base + SP_W'(BLOCK_SIZE));
                r_fpos     <= '0;
                if (r_lo >= eff_cnt) begin
                    r_status <= ST_OUTRANGE;
                    r_blk    <= '0;
                end else begin
                    r_status <= ST_NOTFOUND;
                    r_blk    <= r_lo[BLKOUT_W-1:0];
                end
            end
            OP_SCAN_CMP: begin
                if (ds_rdata == r_key) begin
                    r_status <= ST_FOUND;
                    r_fpos   <= r_scan_pos[POS_W-1:0];
                end
                r_scan_pos <= SP_W'(r_scan_pos + 1'b1);
            end
            default: begin
            end
        endcase
    end

    // Configuration register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= CNT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_block_count <= i_cfg_wr_data;
            end
            if (i_op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT && out_free) begin
            r_out_data <= '{r_status, r_fpos, r_blk};
        end
    end

    assign o_flags.in_valid  = i_in_valid;
    assign o_flags.is_search = (r_kind == KIND_SEARCH);
    assign o_flags.lo_ge_hi  = (r_lo >= r_hi);
    assign o_flags.lo_ge_cnt = (r_lo >= eff_cnt);
    assign o_flags.scan_done = (r_scan_pos == r_scan_end) ||
                               (r_scan_pos >= SP_W'(STORE_DEPTH));
    assign o_flags.no_match  = (ds_rdata != r_key);
    assign o_flags.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/block_index_search_top.sv
// Indexed block search over a 64-entry store of 16-bit values, cut into
// NUM_BLOCKS blocks of BLOCK_SIZE positions with a running maximum per block.
// A load transaction writes one value and updates its block maximum. A search
// transaction runs binary-search probes over the block maxima (at most
// ceil(log2(block_count + 1)) probes), then compares the elements of the
// chosen block until a match or the end of the block; a key above every block
// skips the compares. The control store runs one step per cycle, with each
// probe and each scan compare waiting on a registered RAM read. Only one
// transaction is in flight at a time; a finished result waits in the output
// register while the next transaction is accepted. The user must write
// block_count only while idle; the block itself does not enforce this. The
// count is clamped to NUM_BLOCKS; a count of zero reports every key as above
// all blocks.
module block_index_search_top #(
    parameter int BLOCK_SIZE = 4,
    parameter int NUM_BLOCKS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bis_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bis_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_wr_en,
    input  logic [bis_pkg::CNT_W-1:0] i_cfg_wr_data
);

    import bis_pkg::*;

    t_op    op;
    t_flags flags;

    assign o_in_stall = (op != OP_ACCEPT);

    bis_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op)
    );

    bis_datapath #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_flags       (flags),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    // One transaction at a time: the port closes right after an acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction is in flight");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_LOADED) |->
        (o_out_data.found_position == '0 && o_out_data.block_searched == '0))
        else $error("load result carries a position or block");

    a_outrange_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_OUTRANGE) |->
        (o_out_data.found_position == '0 && o_out_data.block_searched == '0))
        else $error("out-of-range result carries a position or block");

endmodule

// File: tb/block_index_search_checker.sv
module block_index_search_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  bis_pkg::t_in_item         i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  bis_pkg::t_out_item        i_out_data,
    input  logic                      i_cfg_wr_en,
    input  logic [bis_pkg::CNT_W-1:0] i_cfg_wr_data,
    output int                        o_fail_count,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int BLOCK_SIZE = 4;
    localparam int NUM_BLOCKS = 16;

    logic [VALUE_W-1:0] elem_mirror [STORE_DEPTH];
    logic [VALUE_W-1:0] max_mirror  [NUM_BLOCKS];
    logic [CNT_W-1:0]   count_mirror = CNT_RESET;
    t_out_item          outcomes_due [$];

    // Applies one transaction to the mirrored store and index, and returns the
    // result the block has to produce for it.
    function automatic t_out_item resolve_item(input t_in_item it);
        int unsigned blk;
        int unsigned cnt;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned base;
        int unsigned p;
        bit          hit;
        t_out_item   r;
        r = '0;
        if (it.kind == KIND_LOAD) begin
            blk = it.position / BLOCK_SIZE;
            elem_mirror[it.position] = it.value;
            if (blk < NUM_BLOCKS &&
                (it.position % BLOCK_SIZE == 0 || it.value > max_mirror[blk])) begin
                max_mirror[blk] = it.value;
            end
            r.status = ST_LOADED;
        end else begin
            cnt = (count_mirror > NUM_BLOCKS) ? NUM_BLOCKS : count_mirror;
            lo  = 0;
            hi  = cnt;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (max_mirror[mid] < it.value) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            if (lo >= cnt) begin
                r.status = ST_OUTRANGE;
            end else begin
                r.status         = ST_NOTFOUND;
                r.block_searched = BLKOUT_W'(lo);
                base = lo * BLOCK_SIZE;
                hit  = 1'b0;
                for (int j = 0; j < BLOCK_SIZE && !hit; j++) begin
                    p = base + j;
                    if (p < STORE_DEPTH && elem_mirror[p] == it.value) begin
                        hit              = 1'b1;
                        r.status         = ST_FOUND;
                        r.found_position = POS_W'(p);
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            count_mirror = CNT_RESET;
            outcomes_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                count_mirror = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (outcomes_due.size() == 0) begin
                    $error("result transaction with nothing expected: status %0d",
                           i_out_data.status);
                    o_fail_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_data.status));
                    check_field("found_position", 32'(want.found_position),
                                32'(i_out_data.found_position));
                    check_field("block_searched", 32'(want.block_searched),
                                32'(i_out_data.block_searched));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outcomes_due.push_back(resolve_item(i_in_data));
            end
        end
        o_outstanding = outcomes_due.size();
    end

endmodule

// File: tb/block_index_search_top_test.sv
module block_index_search_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int BLOCK_SIZE       = 4;
    localparam int NUM_BLOCKS       = 16;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RANDOM_PER_PHASE = 92;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    t_in_item           in_data     = '0;
    logic               out_stall   = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_data;
    int                 fail_count;
    int                 outstanding;
    int                 cycle_count = 0;
    int                 stall_run   = 0;
    int                 zero_gap_left = 0;
    logic [CNT_W-1:0]   block_count_now = CNT_RESET;

    // What has been loaded so far; used only to keep the stimulus legal and
    // to aim search keys at stored values.
    logic [VALUE_W-1:0] shadow_val [STORE_DEPTH];
    bit                 shadow_ok  [STORE_DEPTH];

    block_index_search_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    block_index_search_checker search_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pause_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    // Output back-pressure: short stalls mostly, a few long ones, and now and
    // then a long stretch with no stall at all.
    always @(posedge clk) begin : stall_gen
        int unsigned roll;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(30, 100);
            end else if (roll < 50) begin
                out_stall <= 1'b1;
                stall_run <= pause_len() - 1;
            end else begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 6);
            end
        end
    end

    function automatic int active_blocks();
        return (block_count_now > NUM_BLOCKS) ? NUM_BLOCKS : block_count_now;
    endfunction

    // A load off a block's first position compares against that block's
    // maximum, so it is only legal once the first position has been written.
    function automatic bit load_legal(input int p);
        return (p % BLOCK_SIZE == 0) || shadow_ok[p - p % BLOCK_SIZE];
    endfunction

    function automatic bit blocks_ready();
        for (int p = 0; p < active_blocks() * BLOCK_SIZE; p++) begin
            if (!shadow_ok[p]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int find_unwritten(input int span);
        int start;
        int p;
        start = $urandom_range(0, span - 1);
        for (int k = 0; k < span; k++) begin
            p = (start + k) % span;
            if (!shadow_ok[p] && load_legal(p)) begin
                return p;
            end
        end
        return -1;
    endfunction

    task automatic issue(input logic kind, input logic [POS_W-1:0] pos,
                         input logic [VALUE_W-1:0] val);
        t_in_item it;
        int       gap;
        it.kind     = kind;
        it.position = pos;
        it.value    = val;
        if (kind == KIND_LOAD) begin
            shadow_val[pos] = val;
            shadow_ok[pos]  = 1'b1;
        end
        if (zero_gap_left > 0) begin
            zero_gap_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 5) begin
                zero_gap_left = $urandom_range(10, 30);
            end
            gap = ($urandom_range(0, 99) < 40) ? 0 : pause_len();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic set_block_count(input logic [CNT_W-1:0] count);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        block_count_now = count;
    endtask

    task automatic random_item();
        int                 p;
        int                 span;
        int unsigned        roll;
        logic [VALUE_W-1:0] v;
        bit                 ready;
        span  = active_blocks() * BLOCK_SIZE;
        ready = blocks_ready();
        if (!ready || $urandom_range(0, 99) < 40) begin
            // Until every block in use is filled, loads go mostly to positions
            // that have never been written, so searches can start early.
            p = -1;
            if ($urandom_range(0, 99) < (ready ? 30 : 90)) begin
                if (span > 0) begin
                    p = find_unwritten(span);
                end
                if (p < 0) begin
                    p = find_unwritten(STORE_DEPTH);
                end
            end
            while (p < 0 || !load_legal(p)) begin
                p = $urandom_range(0, STORE_DEPTH - 1);
            end
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                v = VALUE_W'($urandom_range(0, 15));
            end else if (roll < 35) begin
                v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
                v = VALUE_W'($urandom);
            end
            issue(KIND_LOAD, POS_W'(p), v);
        end else begin
            roll = $urandom_range(0, 99);
            if (span > 0 && roll < 55) begin
                v = shadow_val[$urandom_range(0, span - 1)];
                if (roll < 10) begin
                    v = v + 1'b1;
                end
            end else if (roll < 70) begin
                v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
                v = VALUE_W'($urandom);
            end
            issue(KIND_SEARCH, POS_W'($urandom_range(0, STORE_DEPTH - 1)), v);
        end
    endtask

    initial begin
        logic [CNT_W-1:0] phase_counts [8];
        phase_counts = '{5'd5, 5'd16, 5'd31, 5'd0, 5'd2, 5'd8, 5'd17, 5'd16};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // With no blocks in use every key is reported above all blocks.
        set_block_count(5'd0);
        issue(KIND_SEARCH, 6'd63, 16'hFFFF);
        issue(KIND_SEARCH, 6'd0, 16'h0000);
        // Block 0: first position sets the maximum, a smaller value leaves it,
        // a larger one raises it, and a duplicate sits behind the first copy.
        issue(KIND_LOAD, 6'd0, 16'h0010);
        issue(KIND_LOAD, 6'd1, 16'h0008);
        issue(KIND_LOAD, 6'd2, 16'h0030);
        issue(KIND_LOAD, 6'd3, 16'h0010);

        set_block_count(5'd1);
        issue(KIND_SEARCH, 6'd21, 16'h0010);
        issue(KIND_SEARCH, 6'd42, 16'h0030);
        issue(KIND_SEARCH, 6'd0, 16'h0031);
        issue(KIND_SEARCH, 6'd0, 16'h000F);
        issue(KIND_SEARCH, 6'd63, 16'h0000);
        issue(KIND_LOAD, 6'd0, 16'hFFFF);
        issue(KIND_SEARCH, 6'd0, 16'hFFFF);
        issue(KIND_SEARCH, 6'd0, 16'h0030);
        // Rewriting the first position drops the maximum below the rest of
        // the block, so a key held further in is now out of range.
        issue(KIND_LOAD, 6'd0, 16'h0000);
        issue(KIND_SEARCH, 6'd0, 16'h0030);
        issue(KIND_SEARCH, 6'd0, 16'h0000);
        issue(KIND_LOAD, 6'd1, 16'h0008);
        issue(KIND_SEARCH, 6'd0, 16'h0008);
        issue(KIND_LOAD, 6'd0, 16'h0010);

        foreach (phase_counts[i]) begin
            set_block_count(phase_counts[i]);
            repeat (RANDOM_PER_PHASE) random_item();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
